>>> design/drst_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// drst_pkg
// Types and constants shared by the dead-reckoning servo timer.
// ---------------------------------------------------------------------------
package drst_pkg;

    typedef struct packed {
        logic        kind;
        logic [2:0]  servo_index;
        logic [11:0] target_angle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  servo_number;
        logic [3:0]  pwm_channel;
        logic [11:0] pulse_value;
        logic        is_stop;
        logic        last_of_run;
    } t_out_item;

    typedef enum logic [2:0] {
        CFG_MS_PER_DEGREE    = 3'd0,
        CFG_FORWARD_PULSE    = 3'd1,
        CFG_BACKWARD_PULSE   = 3'd2,
        CFG_DEAD_ZONE_TENTHS = 3'd3,
        CFG_UPDATE_PERIOD_MS = 3'd4,
        CFG_CHANNEL_MAP      = 3'd5
    } t_cfg_reg;

    localparam logic KIND_TARGET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic [11:0] HOME_ANGLE  = 12'd1270;
    localparam logic [16:0] ELAPSED_MAX = 17'd131071;
    localparam int          MAP_SLOTS   = 6;

    // Division by ten of a product below 2**20: multiply by ceil(2**24 / 10).
    localparam logic [20:0] RECIP_TEN   = 21'd1677722;
    localparam int          RECIP_SHIFT = 24;

    localparam logic [7:0]  RST_MS_PER_DEGREE    = 8'd5;
    localparam logic [11:0] RST_FORWARD_PULSE    = 12'd400;
    localparam logic [11:0] RST_BACKWARD_PULSE   = 12'd200;
    localparam logic [11:0] RST_DEAD_ZONE_TENTHS = 12'd5;
    localparam logic [7:0]  RST_UPDATE_PERIOD_MS = 8'd10;
    localparam logic [23:0] RST_CHANNEL_MAP      = 24'hFB9640;

endpackage
`default_nettype wire

>>> design/dead_reckoning_servo_timer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dead_reckoning_servo_timer
// Open-loop spin timing for a bank of continuous-rotation servos.
// ---------------------------------------------------------------------------
// A target transfer produces no result. A tick transfer runs one pass over all
// servos, and output stall can lengthen it: each servo is inspected in S_EVAL,
// a moving servo then gets its timing check in S_MOVE, and a servo that starts
// first passes through S_MUL1 and S_MUL2 in the single shared multiplier (angle
// times ms per degree, then the reciprocal of ten) and issues its start command
// in S_START. Input stall is high for the whole pass. One result is held back
// in a staging register so the final result of a pass can carry last_of_run.
// Configuration writes are always accepted.
module dead_reckoning_servo_timer #(
    parameter int SERVO_COUNT = 6
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire drst_pkg::t_in_item i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output drst_pkg::t_out_item   o_out_data,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [2:0]            i_cfg_index,
    input  wire  [23:0]           i_cfg_data
);
    import drst_pkg::*;

    localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SERVO_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL1,
        S_MUL2,
        S_START,
        S_MOVE,
        S_FLUSH
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;

    logic [7:0]  r_ms_per_degree;
    logic [11:0] r_forward_pulse;
    logic [11:0] r_backward_pulse;
    logic [11:0] r_dead_zone;
    logic [7:0]  r_update_period;
    logic [23:0] r_channel_map;

    logic [11:0] r_goal     [SERVO_COUNT];
    logic [11:0] r_believed [SERVO_COUNT];
    logic        r_pending  [SERVO_COUNT];
    logic        r_moving   [SERVO_COUNT];
    logic [16:0] r_duration [SERVO_COUNT];
    logic [16:0] r_elapsed  [SERVO_COUNT];

    logic [11:0] r_mag;
    logic        r_forward;
    logic [19:0] r_prod;
    logic [16:0] r_quot;

    logic        r_hold_v;
    t_out_item   r_hold;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [11:0] cur_goal;
    logic [11:0] cur_believed;
    logic [11:0] cur_mag;
    logic        cur_fwd;
    logic [16:0] cur_elapsed;
    logic [16:0] cur_duration;
    logic [17:0] elapsed_sum;
    logic [16:0] elapsed_next;
    logic [20:0] mul_a;
    logic [20:0] mul_b;
    logic [41:0] mul_p;
    logic [4:0]  idx_ext;
    logic [3:0]  cur_channel;
    logic        out_free;
    logic        push_ok;
    logic        push_req;
    t_out_item   push_item;
    logic        out_load;
    t_out_item   n_out;
    logic        due;
    logic        in_xfer;
    logic [4:0]  tgt_ext;

    assign cur_goal     = r_goal[r_idx];
    assign cur_believed = r_believed[r_idx];
    assign cur_fwd      = cur_goal > cur_believed;
    assign cur_mag      = cur_fwd ? (cur_goal - cur_believed) : (cur_believed - cur_goal);
    assign cur_elapsed  = r_elapsed[r_idx];
    assign cur_duration = r_duration[r_idx];
    assign due          = cur_elapsed >= cur_duration;
    assign elapsed_sum  = {1'b0, cur_elapsed} + {10'd0, r_update_period};
    assign elapsed_next = elapsed_sum[17] ? ELAPSED_MAX : elapsed_sum[16:0];

    always_comb begin
        if (r_state == S_MUL2) begin
            mul_a = {1'b0, r_prod};
            mul_b = RECIP_TEN;
        end else begin
            mul_a = {9'd0, r_mag};
            mul_b = {13'd0, r_ms_per_degree};
        end
    end
    assign mul_p = {21'd0, mul_a} * {21'd0, mul_b};

    assign idx_ext     = 5'(r_idx);
    assign cur_channel = (idx_ext < 5'(MAP_SLOTS)) ?
                         r_channel_map[{idx_ext[2:0], 2'b00} +: 4] : 4'd0;

    assign out_free = !r_out_valid || !i_out_stall;
    assign push_ok  = !r_hold_v || out_free;

    always_comb begin
        push_req                 = 1'b0;
        push_item.servo_number   = 3'(r_idx);
        push_item.pwm_channel    = cur_channel;
        push_item.pulse_value    = 12'd0;
        push_item.is_stop        = 1'b0;
        push_item.last_of_run    = 1'b0;
        case (r_state)
            S_START: begin
                push_req              = 1'b1;
                push_item.pulse_value = r_forward ? r_forward_pulse : r_backward_pulse;
            end
            S_MOVE: begin
                push_req          = due;
                push_item.is_stop = 1'b1;
            end
            default: begin
                push_req = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_load = 1'b0;
        n_out    = r_hold;
        if (push_req && push_ok && r_hold_v) begin
            out_load = 1'b1;
        end
        if (r_state == S_FLUSH && r_hold_v && out_free) begin
            out_load          = 1'b1;
            n_out.last_of_run = 1'b1;
        end
    end

    assign in_xfer = i_in_valid && !o_in_stall;
    assign tgt_ext = {2'b00, i_in_data.servo_index};

    assign o_in_stall  = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_idx            <= '0;
            r_hold_v         <= 1'b0;
            r_out_valid      <= 1'b0;
            r_ms_per_degree  <= RST_MS_PER_DEGREE;
            r_forward_pulse  <= RST_FORWARD_PULSE;
            r_backward_pulse <= RST_BACKWARD_PULSE;
            r_dead_zone      <= RST_DEAD_ZONE_TENTHS;
            r_update_period  <= RST_UPDATE_PERIOD_MS;
            r_channel_map    <= RST_CHANNEL_MAP;
            for (int k = 0; k < SERVO_COUNT; k++) begin
                r_goal[k]     <= HOME_ANGLE;
                r_believed[k] <= HOME_ANGLE;
                r_pending[k]  <= 1'b0;
                r_moving[k]   <= 1'b0;
                r_duration[k] <= '0;
                r_elapsed[k]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MS_PER_DEGREE:    r_ms_per_degree  <= i_cfg_data[7:0];
                    CFG_FORWARD_PULSE:    r_forward_pulse  <= i_cfg_data[11:0];
                    CFG_BACKWARD_PULSE:   r_backward_pulse <= i_cfg_data[11:0];
                    CFG_DEAD_ZONE_TENTHS: r_dead_zone      <= i_cfg_data[11:0];
                    CFG_UPDATE_PERIOD_MS: r_update_period  <= i_cfg_data[7:0];
                    CFG_CHANNEL_MAP:      r_channel_map    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (push_req && push_ok) begin
                r_hold   <= push_item;
                r_hold_v <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_in_data.kind == KIND_TICK) begin
                            r_idx   <= '0;
                            r_state <= S_EVAL;
                        end else if (tgt_ext < 5'(SERVO_COUNT)) begin
                            r_goal[IDX_W'(i_in_data.servo_index)]    <= i_in_data.target_angle;
                            r_pending[IDX_W'(i_in_data.servo_index)] <= 1'b1;
                        end
                    end
                end
                S_EVAL: begin
                    if (r_pending[r_idx] && !r_moving[r_idx]) begin
                        if (cur_mag < r_dead_zone) begin
                            r_believed[r_idx] <= cur_goal;
                            r_pending[r_idx]  <= 1'b0;
                            if (r_idx == LAST_IDX) begin
                                r_state <= S_FLUSH;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end else begin
                            r_mag     <= cur_mag;
                            r_forward <= cur_fwd;
                            r_state   <= S_MUL1;
                        end
                    end else if (r_moving[r_idx]) begin
                        r_state <= S_MOVE;
                    end else if (r_idx == LAST_IDX) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MUL1: begin
                    r_prod  <= mul_p[19:0];
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_quot  <= mul_p[RECIP_SHIFT +: 17];
                    r_state <= S_START;
                end
                S_START: begin
                    if (push_ok) begin
                        r_duration[r_idx] <= r_quot;
                        r_elapsed[r_idx]  <= '0;
                        r_moving[r_idx]   <= 1'b1;
                        r_pending[r_idx]  <= 1'b0;
                        r_state           <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    if (!due || push_ok) begin
                        if (due) begin
                            r_believed[r_idx] <= cur_goal;
                            r_moving[r_idx]   <= 1'b0;
                        end else begin
                            r_elapsed[r_idx] <= elapsed_next;
                        end
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_hold_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_hold_only_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> r_state != S_IDLE)
        else $error("staged result left behind after the pass ended");

    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL2 |-> $past(r_state) == S_MUL1)
        else $error("reciprocal multiply without a preceding product");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_START |-> r_quot <= 17'd104422)
        else $error("spin duration beyond the largest possible quotient");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && r_hold_v && out_free) |=> (r_out_valid && r_out.last_of_run))
        else $error("final result of a pass not marked last");

endmodule
`default_nettype wire
